// File: hdl/fccr_pkg.sv
`timescale 1ns / 1ps
package fccr_pkg;

	localparam int DATA_W   = 32;
	localparam int MU_W     = 18;
	localparam int MU_FRAC  = 16;
	localparam int ACC_W    = 64;

	// Iterative multiplier: first factor, second factor (one bit per step), product.
	localparam int MUL_A_W  = 60;
	localparam int MUL_B_W  = 44;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

	// Digit-by-digit square root.
	localparam int SQRT_IN_W  = 66;
	localparam int SQRT_OUT_W = SQRT_IN_W / 2;
	localparam int SQRT_REM_W = SQRT_OUT_W + 4;

	// Restoring divider.
	localparam int DIV_N_W = 92;
	localparam int DIV_D_W = 50;

	// Signed working values and their magnitudes.
	localparam int MAG_W  = MUL_B_W;
	localparam int PROJ_W = 42;
	localparam int SUM_W  = 88;

	typedef struct packed {
		logic                     start_req;
		logic signed [DATA_W-1:0] force_n;
		logic signed [DATA_W-1:0] force_t1;
		logic signed [DATA_W-1:0] force_t2;
		logic signed [DATA_W-1:0] vel_n;
		logic signed [DATA_W-1:0] vel_t1;
		logic signed [DATA_W-1:0] vel_t2;
		logic [MU_W-1:0]          friction;
	} contact_in_t;

	typedef struct packed {
		logic [ACC_W-1:0] contact_error;
		logic [ACC_W-1:0] error_sum;
		logic [1:0]       cone_case;
	} contact_out_t;

	typedef enum logic [1:0] {
		REGION_ZERO     = 2'd0,
		REGION_INSIDE   = 2'd1,
		REGION_BOUNDARY = 2'd2
	} region_t;

	typedef enum logic [4:0] {
		OP_VT1_SQ,
		OP_VT2_SQ,
		OP_SQRT_V,
		OP_MU_NUT,
		OP_A1_SQ,
		OP_A2_SQ,
		OP_SQRT_D,
		OP_MU_NT,
		OP_MU_D0,
		OP_REGION,
		OP_MU_MU,
		OP_DIV_P0,
		OP_MU_P0,
		OP_M_A1,
		OP_DIV_1,
		OP_M_A2,
		OP_DIV_2,
		OP_E0_SQ,
		OP_E1_SQ,
		OP_E2_SQ,
		OP_FINISH
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic launch;
		logic capture;
		logic finish;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic    done;
		region_t region;
	} status_t;

	function automatic logic [MAG_W-1:0] mag_of(input logic signed [MAG_W-1:0] v);
		return v[MAG_W-1] ? $unsigned(-v) : $unsigned(v);
	endfunction

endpackage

// File: hdl/fccr_stream_if.sv
`timescale 1ns / 1ps
interface fccr_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/fccr_mul.sv
`timescale 1ns / 1ps
module fccr_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [fccr_pkg::MUL_A_W-1:0]   a,
	input  logic [fccr_pkg::MUL_B_W-1:0]   b,
	output logic                           done,
	output logic [fccr_pkg::MUL_P_W-1:0]   product
);
	import fccr_pkg::*;

	logic                busy_q;
	logic [MUL_P_W-1:0]  a_q;
	logic [MUL_B_W-1:0]  b_q;
	logic [MUL_P_W-1:0]  acc_q;

	// The run ends as soon as no set bit of the second factor is left.
	assign done    = busy_q && (b_q == '0);
	assign product = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= MUL_P_W'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end
endmodule

// File: hdl/fccr_sqrt.sv
`timescale 1ns / 1ps
module fccr_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [fccr_pkg::SQRT_IN_W-1:0]    radicand,
	output logic                              done,
	output logic [fccr_pkg::SQRT_OUT_W-1:0]   root
);
	import fccr_pkg::*;

	localparam int CNT_W = $clog2(SQRT_OUT_W + 1);

	logic                   busy_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [SQRT_IN_W-1:0]   rad_q;
	logic [SQRT_REM_W-1:0]  rem_q;
	logic [SQRT_OUT_W-1:0]  root_q;
	logic [SQRT_REM_W-1:0]  rem_sh;
	logic [SQRT_REM_W-1:0]  trial;

	assign done = busy_q && (cnt_q == '0);
	assign root = root_q;

	always_comb begin
		rem_sh = {rem_q[SQRT_REM_W-3:0], rad_q[SQRT_IN_W-1 -: 2]};
		trial  = SQRT_REM_W'({root_q, 2'b01});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(SQRT_OUT_W);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// One root bit per cycle, taking the radicand two bits at a time from the top.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			rad_q <= rad_q << 2;
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[SQRT_OUT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[SQRT_OUT_W-2:0], 1'b0};
			end
		end
	end
endmodule

// File: hdl/fccr_div.sv
`timescale 1ns / 1ps
module fccr_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [fccr_pkg::DIV_N_W-1:0]   numer,
	input  logic [fccr_pkg::DIV_D_W-1:0]   denom,
	output logic                           done,
	output logic [fccr_pkg::DIV_N_W-1:0]   quotient
);
	import fccr_pkg::*;

	localparam int CNT_W = $clog2(DIV_N_W + 1);

	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIV_N_W-1:0]    num_q;
	logic [DIV_D_W-1:0]    den_q;
	logic [DIV_D_W:0]      rem_q;
	logic [DIV_N_W-1:0]    quo_q;
	logic [DIV_D_W:0]      rem_sh;

	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;
	assign rem_sh   = {rem_q[DIV_D_W-1:0], num_q[DIV_N_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_N_W);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Restoring division; a zero divisor gives a quotient of all ones.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			num_q <= num_q << 1;
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= rem_sh - {1'b0, den_q};
				quo_q <= {quo_q[DIV_N_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DIV_N_W-2:0], 1'b0};
			end
		end
	end
endmodule

// File: hdl/fccr_datapath.sv
`timescale 1ns / 1ps
module fccr_datapath #(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fccr_pkg::cmd_t          cmd,
	output fccr_pkg::status_t       status,
	input  fccr_pkg::contact_in_t   in_data,
	output fccr_pkg::contact_out_t  out_data
);
	import fccr_pkg::*;

	localparam int SH       = 2 * FRAC_BITS - 16;
	localparam int EXT_W    = SUM_W + 16;
	localparam int MUNUT_W  = 35;
	localparam int D0_W     = 37;
	localparam int D1_W     = DATA_W + 1;
	localparam int NT_W     = SQRT_OUT_W;
	localparam int LHS_W    = 51;
	localparam int MUD0_W   = 55;
	localparam int DEN_W    = 38;
	localparam int M_W      = 59;
	localparam logic [DIV_N_W-1:0] CLAMP = DIV_N_W'(1) << 40;

	contact_in_t               in_q;
	logic [SUM_W-1:0]          sq_q;
	logic [NT_W-1:0]           nut_q;
	logic signed [D0_W-1:0]    d0_q;
	logic signed [D1_W-1:0]    d1_q;
	logic signed [D1_W-1:0]    d2_q;
	logic [DATA_W-1:0]         a1_q;
	logic [DATA_W-1:0]         a2_q;
	logic [NT_W-1:0]           nt_q;
	logic [LHS_W-1:0]          lhs_q;
	logic signed [MUD0_W-1:0]  mud0_q;
	region_t                   region_q;
	logic [DEN_W-1:0]          den_q;
	logic [M_W-1:0]            m_q;
	logic [DIV_N_W-1:0]        numer_q;
	logic signed [PROJ_W-1:0]  p0_q;
	logic signed [PROJ_W-1:0]  p1_q;
	logic signed [PROJ_W-1:0]  p2_q;
	logic [ACC_W-1:0]          acc_q;
	contact_out_t              out_q;

	logic                      mul_go;
	logic                      sqrt_go;
	logic                      div_go;
	logic [MUL_A_W-1:0]        mul_a;
	logic [MUL_B_W-1:0]        mul_b;
	logic [DIV_N_W-1:0]        div_n;
	logic [DIV_D_W-1:0]        div_d;
	logic                      mul_done;
	logic                      sqrt_done;
	logic                      div_done;
	logic [MUL_P_W-1:0]        mul_p;
	logic [SQRT_OUT_W-1:0]     sqrt_r;
	logic [DIV_N_W-1:0]        div_q;

	logic [MUNUT_W-1:0]        munut;
	logic signed [D0_W-1:0]    d0_next;
	logic signed [D1_W-1:0]    d1_next;
	logic signed [D1_W-1:0]    d2_next;
	logic signed [MUD0_W-1:0]  num;
	region_t                   region;
	logic [PROJ_W-1:0]         q_clamped;
	logic signed [MAG_W-1:0]   e0;
	logic signed [MAG_W-1:0]   e1;
	logic signed [MAG_W-1:0]   e2;
	logic [EXT_W-1:0]          ext_sh;
	logic [ACC_W-1:0]          err;
	logic [ACC_W-1:0]          acc_base;
	logic [ACC_W:0]            acc_sum;
	logic [ACC_W-1:0]          acc_next;

	fccr_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_go),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_p)
	);

	fccr_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_go),
		.radicand (sq_q[SQRT_IN_W-1:0]),
		.done     (sqrt_done),
		.root     (sqrt_r)
	);

	fccr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.numer    (div_n),
		.denom    (div_d),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		munut   = mul_p[MU_FRAC +: MUNUT_W];
		d0_next = D0_W'(in_q.force_n) - D0_W'(in_q.vel_n) - $signed({2'b0, munut});
		d1_next = D1_W'(in_q.force_t1) - D1_W'(in_q.vel_t1);
		d2_next = D1_W'(in_q.force_t2) - D1_W'(in_q.vel_t2);

		// num is mu*|d_t| + d_n, both with the 16 fraction bits of mu added.
		num = $signed({4'b0, lhs_q}) + MUD0_W'($signed({d0_q, 16'b0}));
		if (num <= 0) begin
			region = REGION_ZERO;
		end else if ($signed({6'b0, nt_q, 16'b0}) <= mud0_q) begin
			region = REGION_INSIDE;
		end else begin
			region = REGION_BOUNDARY;
		end

		q_clamped = (div_q > CLAMP) ? PROJ_W'(CLAMP) : div_q[PROJ_W-1:0];

		e0 = MAG_W'(in_q.force_n) - MAG_W'(p0_q);
		e1 = MAG_W'(in_q.force_t1) - MAG_W'(p1_q);
		e2 = MAG_W'(in_q.force_t2) - MAG_W'(p2_q);

		// The sum of squares has 2*FRAC_BITS fraction bits; bring it to 32.
		ext_sh   = {sq_q, 16'b0} >> SH;
		err      = (|ext_sh[EXT_W-1:ACC_W]) ? '1 : ext_sh[ACC_W-1:0];
		acc_base = in_q.start_req ? '0 : acc_q;
		acc_sum  = {1'b0, acc_base} + {1'b0, err};
		acc_next = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
	end

	always_comb begin
		mul_go  = 1'b0;
		sqrt_go = 1'b0;
		div_go  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		div_n   = '0;
		div_d   = '0;
		unique case (cmd.op)
			OP_VT1_SQ: begin
				mul_go = cmd.launch;
				mul_b  = mag_of(MAG_W'(in_q.vel_t1));
				mul_a  = MUL_A_W'(mul_b);
			end
			OP_VT2_SQ: begin
				mul_go = cmd.launch;
				mul_b  = mag_of(MAG_W'(in_q.vel_t2));
				mul_a  = MUL_A_W'(mul_b);
			end
			OP_SQRT_V, OP_SQRT_D: begin
				sqrt_go = cmd.launch;
			end
			OP_MU_NUT: begin
				mul_go = cmd.launch;
				mul_a  = MUL_A_W'(nut_q);
				mul_b  = MUL_B_W'(in_q.friction);
			end
			OP_A1_SQ: begin
				mul_go = cmd.launch;
				mul_a  = MUL_A_W'(a1_q);
				mul_b  = MUL_B_W'(a1_q);
			end
			OP_A2_SQ: begin
				mul_go = cmd.launch;
				mul_a  = MUL_A_W'(a2_q);
				mul_b  = MUL_B_W'(a2_q);
			end
			OP_MU_NT: begin
				mul_go = cmd.launch;
				mul_a  = MUL_A_W'(nt_q);
				mul_b  = MUL_B_W'(in_q.friction);
			end
			OP_MU_D0: begin
				mul_go = cmd.launch;
				mul_a  = MUL_A_W'(mag_of(MAG_W'(d0_q)));
				mul_b  = MUL_B_W'(in_q.friction);
			end
			OP_MU_MU: begin
				mul_go = cmd.launch;
				mul_a  = MUL_A_W'(in_q.friction);
				mul_b  = MUL_B_W'(in_q.friction);
			end
			OP_DIV_P0: begin
				div_go = cmd.launch;
				div_n  = {22'b0, num[MUD0_W-2:0], 16'b0};
				div_d  = DIV_D_W'(den_q);
			end
			OP_MU_P0: begin
				mul_go = cmd.launch;
				mul_a  = MUL_A_W'(p0_q[PROJ_W-2:0]);
				mul_b  = MUL_B_W'(in_q.friction);
			end
			OP_M_A1: begin
				mul_go = cmd.launch;
				mul_a  = MUL_A_W'(m_q);
				mul_b  = MUL_B_W'(a1_q);
			end
			OP_M_A2: begin
				mul_go = cmd.launch;
				mul_a  = MUL_A_W'(m_q);
				mul_b  = MUL_B_W'(a2_q);
			end
			OP_DIV_1, OP_DIV_2: begin
				div_go = cmd.launch;
				div_n  = numer_q;
				div_d  = {1'b0, nt_q, 16'b0};
			end
			OP_E0_SQ: begin
				mul_go = cmd.launch;
				mul_b  = mag_of(e0);
				mul_a  = MUL_A_W'(mul_b);
			end
			OP_E1_SQ: begin
				mul_go = cmd.launch;
				mul_b  = mag_of(e1);
				mul_a  = MUL_A_W'(mul_b);
			end
			OP_E2_SQ: begin
				mul_go = cmd.launch;
				mul_b  = mag_of(e2);
				mul_a  = MUL_A_W'(mul_b);
			end
			default: begin
			end
		endcase
	end

	assign status.done   = mul_done | sqrt_done | div_done;
	assign status.region = region;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_data;
		end
		if (cmd.capture) begin
			unique case (cmd.op)
				OP_VT1_SQ, OP_A1_SQ, OP_E0_SQ: sq_q <= mul_p[SUM_W-1:0];
				OP_VT2_SQ, OP_A2_SQ, OP_E1_SQ, OP_E2_SQ: sq_q <= sq_q + mul_p[SUM_W-1:0];
				OP_SQRT_V: nut_q <= sqrt_r;
				OP_MU_NUT: begin
					d0_q <= d0_next;
					d1_q <= d1_next;
					d2_q <= d2_next;
					a1_q <= DATA_W'(mag_of(MAG_W'(d1_next)));
					a2_q <= DATA_W'(mag_of(MAG_W'(d2_next)));
				end
				OP_SQRT_D: nt_q <= sqrt_r;
				OP_MU_NT: lhs_q <= mul_p[LHS_W-1:0];
				OP_MU_D0: begin
					mud0_q <= d0_q[D0_W-1] ? -$signed({1'b0, mul_p[MUD0_W-2:0]})
						: $signed({1'b0, mul_p[MUD0_W-2:0]});
				end
				OP_REGION: begin
					region_q <= region;
					if (region == REGION_INSIDE) begin
						p0_q <= PROJ_W'(d0_q);
						p1_q <= PROJ_W'(d1_q);
						p2_q <= PROJ_W'(d2_q);
					end else begin
						p0_q <= '0;
						p1_q <= '0;
						p2_q <= '0;
					end
				end
				OP_MU_MU: den_q <= {2'b0, mul_p[DEN_W-3:0]} + (DEN_W'(1) << 32);
				OP_DIV_P0: p0_q <= $signed(q_clamped);
				OP_MU_P0: m_q <= mul_p[M_W-1:0];
				OP_M_A1, OP_M_A2: numer_q <= mul_p[DIV_N_W-1:0];
				OP_DIV_1: begin
					if (nt_q == '0) begin
						p1_q <= '0;
					end else begin
						p1_q <= d1_q[D1_W-1] ? -$signed(q_clamped) : $signed(q_clamped);
					end
				end
				OP_DIV_2: begin
					if (nt_q == '0) begin
						p2_q <= '0;
					end else begin
						p2_q <= d2_q[D1_W-1] ? -$signed(q_clamped) : $signed(q_clamped);
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.finish) begin
			out_q.contact_error <= err;
			out_q.error_sum     <= acc_next;
			out_q.cone_case     <= region_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.finish) begin
			acc_q <= acc_next;
		end
	end

	assign out_data = out_q;
endmodule

// File: hdl/fccr_ctrl.sv
`timescale 1ns / 1ps
module fccr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output fccr_pkg::cmd_t     cmd,
	input  fccr_pkg::status_t  status
);
	import fccr_pkg::*;

	state_t state_q;
	state_t state_d;
	op_t    op_q;
	op_t    op_d;
	logic   out_valid_q;

	function automatic op_t next_op(input op_t op, input region_t region);
		unique case (op)
			OP_VT1_SQ: return OP_VT2_SQ;
			OP_VT2_SQ: return OP_SQRT_V;
			OP_SQRT_V: return OP_MU_NUT;
			OP_MU_NUT: return OP_A1_SQ;
			OP_A1_SQ:  return OP_A2_SQ;
			OP_A2_SQ:  return OP_SQRT_D;
			OP_SQRT_D: return OP_MU_NT;
			OP_MU_NT:  return OP_MU_D0;
			OP_MU_D0:  return OP_REGION;
			// Only a boundary projection needs the divisions.
			OP_REGION: return (region == REGION_BOUNDARY) ? OP_MU_MU : OP_E0_SQ;
			OP_MU_MU:  return OP_DIV_P0;
			OP_DIV_P0: return OP_MU_P0;
			OP_MU_P0:  return OP_M_A1;
			OP_M_A1:   return OP_DIV_1;
			OP_DIV_1:  return OP_M_A2;
			OP_M_A2:   return OP_DIV_2;
			OP_DIV_2:  return OP_E0_SQ;
			OP_E0_SQ:  return OP_E1_SQ;
			OP_E1_SQ:  return OP_E2_SQ;
			default:   return OP_FINISH;
		endcase
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_VT1_SQ;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		cmd      = '0;
		cmd.op   = op_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					op_d     = OP_VT1_SQ;
					state_d  = ST_LAUNCH;
				end
			end
			ST_LAUNCH: begin
				if (op_q == OP_REGION) begin
					cmd.capture = 1'b1;
					op_d        = next_op(op_q, status.region);
				end else begin
					cmd.launch = 1'b1;
					state_d    = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (status.done) begin
					cmd.capture = 1'b1;
					op_d        = next_op(op_q, status.region);
					state_d     = (op_d == OP_FINISH) ? ST_FINISH : ST_LAUNCH;
				end
			end
			ST_FINISH: begin
				// The result register is written only once the previous item has left it.
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
endmodule

// File: hdl/friction_cone_contact_residual.sv
`timescale 1ns / 1ps
// Computes the natural-map residual of one 3D Coulomb contact per item: the modified
// velocity, the projection of reaction minus velocity onto the friction cone (zeroed,
// inside, or onto the boundary), the squared norm of reaction minus projection in
// Q32.32 with saturation, and a saturating running sum that start_req clears first.
// Items are handled one at a time by a shared bit-serial multiplier, a square-root
// unit and a restoring divider. Each product runs only until no set bit of its second
// factor is left, and an item whose projection lands on the boundary needs three
// divisions, which the zero and inside cases skip. A finished result waits in an
// output register while the next item is taken in.
module friction_cone_contact_residual #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	fccr_stream_if.sink   contact,
	fccr_stream_if.source result
);
	import fccr_pkg::*;

	cmd_t         cmd;
	status_t      status;
	contact_in_t  in_data;
	contact_out_t out_data;

	assign in_data     = contact.data;
	assign result.data = out_data;

	fccr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (contact.valid),
		.in_ready  (contact.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.status    (status)
	);

	fccr_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_data  (in_data),
		.out_data (out_data)
	);

	// The running sum saturates, so it never falls below the item's own error.
	a_sum_covers_error: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.data.error_sum >= result.data.contact_error))
		else $error("error_sum below contact_error");

	// An item needs many cycles; a result cannot appear right after an accept.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(contact.valid && contact.ready) |=> !$rose(result.valid))
		else $error("result appeared one cycle after an accept");

	// When a new result appears the sequencer has returned to taking items.
	a_ready_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> contact.ready)
		else $error("input not ready when a result was produced");
endmodule
